// ===== rtl/core/button_click_classifier_macros.svh =====
// assertion macros used by the button click classifier checker
`ifndef BUTTON_CLICK_CLASSIFIER_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BCC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define BCC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bcc_pkg.sv =====
// shared types and constants of the button click classifier
package bcc_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int NOW_W       = 32;
    localparam int EVENT_W     = 3;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_CLICK_LIMIT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_GAP = 1'd1;

    localparam logic [CFG_DATA_W-1:0] CLICK_LIMIT_RST = 16'd300;
    localparam logic [CFG_DATA_W-1:0] RELEASE_GAP_RST = 16'd200;

    // event codes
    localparam logic [EVENT_W-1:0] EV_NONE   = 3'd0;
    localparam logic [EVENT_W-1:0] EV_SINGLE = 3'd1;
    localparam logic [EVENT_W-1:0] EV_DOUBLE = 3'd2;
    localparam logic [EVENT_W-1:0] EV_TRIPLE = 3'd3;
    localparam logic [EVENT_W-1:0] EV_LONG   = 3'd4;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] click_limit_ms;
        logic [CFG_DATA_W-1:0] release_gap_ms;
    } cfg_t;

endpackage

// ===== rtl/core/button_click_classifier.sv =====
// top level of the button click classifier
//
// each word on the s_ channel is one poll: a millisecond timestamp and the
// button level. every poll yields exactly one word on the m_ channel with
// the event code: none, single, double or triple click, or long press.
// the cfg_ channel writes the click limit (index 0) and the release gap
// (index 1); it is always ready and should be used only while idle.
// the poll is captured in an input register, classified against the stored
// press and release timestamps combinationally, and the event is held in an
// output register; a poll passes the input register and then the output
// register. throughput is one poll per cycle while m_tready stays high.
// when the receiver stalls, the result stays in the output register and the
// input register still takes one more poll; s_tready drops only while both
// are full. reset clears all timestamps, the level history and both
// registers' valid flags, and loads the click limit 300 and release gap 200
module button_click_classifier
    import bcc_pkg::*;
#(
    parameter int TIME_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // now_ms[31:0], pressed, zero pad
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // event_res[2:0], zero pad
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t               cfg;
    logic               in_valid_reg;
    logic               in_valid_next;
    logic [NOW_W-1:0]   in_now_reg;
    logic               in_pressed_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [EVENT_W-1:0] out_event_reg;
    logic [EVENT_W-1:0] event_res;
    logic               out_free;
    logic               step;
    logic               in_take;

    assign cfg_ready = 1'b1;

    bcc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign in_take  = s_tvalid && s_tready;

    bcc_classify #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .now_ms    (in_now_reg),
        .pressed   (in_pressed_reg),
        .cfg       (cfg),
        .event_res (event_res)
    );

    always_comb
    begin
        in_valid_next = in_take || (in_valid_reg && !step);
        out_valid_next = step || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_now_reg     <= s_tdata[NOW_W-1:0];
            in_pressed_reg <= s_tdata[NOW_W];
        end
        if (step)
            out_event_reg <= event_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - EVENT_W){1'b0}}, out_event_reg};

endmodule

// ===== rtl/core/bcc_cfg_regs.sv =====
// configuration registers: click limit and release gap
module bcc_cfg_regs
    import bcc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    output cfg_t                   cfg
);

    logic [CFG_DATA_W-1:0] click_limit_reg;
    logic [CFG_DATA_W-1:0] click_limit_next;
    logic [CFG_DATA_W-1:0] release_gap_reg;
    logic [CFG_DATA_W-1:0] release_gap_next;

    always_comb
    begin
        click_limit_next = click_limit_reg;
        release_gap_next = release_gap_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_CLICK_LIMIT: click_limit_next = wr_data;
                REG_RELEASE_GAP: release_gap_next = wr_data;
                default:
                begin
                    click_limit_next = click_limit_reg;
                    release_gap_next = release_gap_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            click_limit_reg <= CLICK_LIMIT_RST;
            release_gap_reg <= RELEASE_GAP_RST;
        end
        else
        begin
            click_limit_reg <= click_limit_next;
            release_gap_reg <= release_gap_next;
        end
    end

    assign cfg.click_limit_ms = click_limit_reg;
    assign cfg.release_gap_ms = release_gap_reg;

endmodule

// ===== rtl/core/bcc_classify.sv =====
// click state: press and release timestamps, level history and event decode
module bcc_classify
    import bcc_pkg::*;
#(
    parameter int TIME_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [NOW_W-1:0]   now_ms,
    input  logic               pressed,
    input  cfg_t               cfg,
    output logic [EVENT_W-1:0] event_res
);

    localparam logic [TIME_WIDTH-1:0] T_ZERO = '0;

    logic [TIME_WIDTH-1:0] first_reg;
    logic [TIME_WIDTH-1:0] first_next;
    logic [TIME_WIDTH-1:0] second_reg;
    logic [TIME_WIDTH-1:0] second_next;
    logic [TIME_WIDTH-1:0] third_reg;
    logic [TIME_WIDTH-1:0] third_next;
    logic [TIME_WIDTH-1:0] release_reg;
    logic [TIME_WIDTH-1:0] release_next;
    logic                  prev_level_reg;
    logic                  prev_level_next;

    logic [TIME_WIDTH-1:0] now_t;
    logic [TIME_WIDTH-1:0] limit_t;
    logic [TIME_WIDTH-1:0] gap_t;
    logic                  first_old;
    logic                  second_old;
    logic                  third_old;
    logic                  gap_passed;

    assign now_t   = TIME_WIDTH'(now_ms);
    assign limit_t = TIME_WIDTH'(cfg.click_limit_ms);
    assign gap_t   = TIME_WIDTH'(cfg.release_gap_ms);

    // wrapping elapsed times compared against the limits
    assign first_old  = (now_t - first_reg) > limit_t;
    assign second_old = (now_t - second_reg) > limit_t;
    assign third_old  = (now_t - third_reg) > limit_t;
    assign gap_passed = (now_t - release_reg) > gap_t;

    always_comb
    begin
        first_next      = first_reg;
        second_next     = second_reg;
        third_next      = third_reg;
        release_next    = release_reg;
        prev_level_next = pressed;
        event_res       = EV_NONE;

        if (pressed == prev_level_reg)
        begin
            if (!pressed)
            begin
                if (release_reg != T_ZERO && gap_passed)
                begin
                    if (second_reg != T_ZERO)
                        event_res = EV_DOUBLE;
                    else if (first_reg != T_ZERO)
                        event_res = EV_SINGLE;
                    first_next   = T_ZERO;
                    second_next  = T_ZERO;
                    third_next   = T_ZERO;
                    release_next = T_ZERO;
                end
            end
            else if (third_reg != T_ZERO)
            begin
                // held third press: report the two clicks before it
                if (third_old)
                begin
                    event_res    = EV_DOUBLE;
                    first_next   = now_t;
                    second_next  = T_ZERO;
                    third_next   = T_ZERO;
                    release_next = T_ZERO;
                end
            end
            else if (second_reg != T_ZERO)
            begin
                if (second_old)
                begin
                    event_res    = EV_SINGLE;
                    first_next   = now_t;
                    second_next  = T_ZERO;
                    third_next   = T_ZERO;
                    release_next = T_ZERO;
                end
            end
            else if (first_old)
            begin
                event_res = EV_LONG;
            end
        end
        else if (!pressed)
        begin
            if (third_reg != T_ZERO)
            begin
                event_res    = EV_TRIPLE;
                first_next   = T_ZERO;
                second_next  = T_ZERO;
                third_next   = T_ZERO;
                release_next = T_ZERO;
            end
            else if (second_reg == T_ZERO && first_old)
            begin
                // end of a long press
                first_next   = T_ZERO;
                second_next  = T_ZERO;
                third_next   = T_ZERO;
                release_next = T_ZERO;
            end
            else
            begin
                release_next = now_t;
            end
        end
        else
        begin
            if (first_reg == T_ZERO)
                first_next = now_t;
            else if (second_reg == T_ZERO)
                second_next = now_t;
            else if (third_reg == T_ZERO)
                third_next = now_t;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg      <= '0;
            second_reg     <= '0;
            third_reg      <= '0;
            release_reg    <= '0;
            prev_level_reg <= 1'b0;
        end
        else if (step)
        begin
            first_reg      <= first_next;
            second_reg     <= second_next;
            third_reg      <= third_next;
            release_reg    <= release_next;
            prev_level_reg <= prev_level_next;
        end
    end

endmodule

// ===== rtl/core/bcc_checker.sv =====
// port-level checks of the button click classifier, bound to the top level
`include "button_click_classifier_macros.svh"

module bcc_checker
    import bcc_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // a stalled result word keeps its value
    `BCC_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")

    // only the five event codes, padding zero
    `BCC_ASSERT_IMP(a_event_code, m_tvalid, m_tdata[EVENT_W-1:0] <= EV_LONG && m_tdata[OUT_TDATA_W-1:EVENT_W] == '0, "bad event code")

    // input side backs up only behind a stalled full output
    `BCC_ASSERT_IMP(a_stall_cause, !s_tready, m_tvalid && !m_tready, "input stalled with output free")

    // a fresh result must follow a poll taken into the input register
    `BCC_ASSERT_IMP(a_latency, $rose(m_tvalid), $past(s_tvalid && s_tready, 2), "result without a poll two cycles before")

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
